@@ hdl/poly1305_mac_block_top_assert.svh @@
// Assertion macros shared by the Poly1305 MAC block RTL
`ifndef POLY1305_MAC_BLOCK_TOP_ASSERT_SVH
`define POLY1305_MAC_BLOCK_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its cause
`define PMAC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its cause
`define PMAC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/pmac_pkg.sv @@
// Shared types, constants and the multiply schedule of the Poly1305 MAC block
package pmac_pkg;

	// Payload of one message beat
	typedef struct packed {
		logic [63:0] block_low;
		logic [63:0] block_high;
		logic [4:0]  byte_count;
		logic        last;
	} msg_t;

	// Payload of one tag beat
	typedef struct packed {
		logic [63:0] tag_low;
		logic [63:0] tag_high;
	} tag_t;

	// Sideband that travels with a product through the multiplier
	typedef struct packed {
		logic       valid;
		logic [2:0] col;
		logic       col_end;
	} mul_tag_t;

	// One entry of the product-scanning schedule
	typedef struct packed {
		logic [2:0] ai;
		logic [1:0] rj;
		logic [2:0] col;
		logic       col_end;
	} seq_t;

	// Configuration register indexes
	localparam logic [1:0] REG_R_LOW  = 2'd0;
	localparam logic [1:0] REG_R_HIGH = 2'd1;
	localparam logic [1:0] REG_S_LOW  = 2'd2;
	localparam logic [1:0] REG_S_HIGH = 2'd3;

	localparam logic [127:0] R_CLAMP = 128'h0ffffffc_0ffffffc_0ffffffc_0fffffff;
	localparam logic [129:0] P_MOD   = 130'h3_ffff_ffff_ffff_ffff_ffff_ffff_ffff_fffb;

	localparam logic [4:0] CNT_FULL  = 5'd16;
	localparam logic [4:0] MUL_STEPS = 5'd20;
	localparam logic [2:0] COL_LAST  = 3'd7;

	// Limb pairs ordered by output column: acc limb ai (0..4) times r limb rj (0..3)
	function automatic seq_t seq_lookup(input logic [4:0] step);
		seq_t e;
		case (step)
			5'd0:    e = '{3'd0, 2'd0, 3'd0, 1'b1};
			5'd1:    e = '{3'd0, 2'd1, 3'd1, 1'b0};
			5'd2:    e = '{3'd1, 2'd0, 3'd1, 1'b1};
			5'd3:    e = '{3'd0, 2'd2, 3'd2, 1'b0};
			5'd4:    e = '{3'd1, 2'd1, 3'd2, 1'b0};
			5'd5:    e = '{3'd2, 2'd0, 3'd2, 1'b1};
			5'd6:    e = '{3'd0, 2'd3, 3'd3, 1'b0};
			5'd7:    e = '{3'd1, 2'd2, 3'd3, 1'b0};
			5'd8:    e = '{3'd2, 2'd1, 3'd3, 1'b0};
			5'd9:    e = '{3'd3, 2'd0, 3'd3, 1'b1};
			5'd10:   e = '{3'd1, 2'd3, 3'd4, 1'b0};
			5'd11:   e = '{3'd2, 2'd2, 3'd4, 1'b0};
			5'd12:   e = '{3'd3, 2'd1, 3'd4, 1'b0};
			5'd13:   e = '{3'd4, 2'd0, 3'd4, 1'b1};
			5'd14:   e = '{3'd2, 2'd3, 3'd5, 1'b0};
			5'd15:   e = '{3'd3, 2'd2, 3'd5, 1'b0};
			5'd16:   e = '{3'd4, 2'd1, 3'd5, 1'b1};
			5'd17:   e = '{3'd3, 2'd3, 3'd6, 1'b0};
			5'd18:   e = '{3'd4, 2'd2, 3'd6, 1'b1};
			5'd19:   e = '{3'd4, 2'd3, 3'd7, 1'b1};
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

@@ hdl/pmac_stream_if.sv @@
// Valid/ready stream channel carrying one payload per beat
interface pmac_stream_if #(parameter type data_t = logic);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hdl/poly1305_mac_block_top.sv @@
// Poly1305 MAC block top level: key registers, core and tag output register
//
// channel | dir  | payload                                    | handshake
// msg     | sink | block_low, block_high, byte_count, last     | valid/ready
// tag     | src  | tag_low, tag_high                          | valid/ready
// cfg     | sink | cfg_index, cfg_data (r_low..s_high)         | cfg_we, no stall
//
// A block with bytes holds msg.ready low after its beat while it passes through one add, the
// shared 32x32 multiplier (20 products plus one pipeline stage) and four reduction steps.
// An empty block is taken with no multiply; an empty last block goes straight to the tag.
// A last block then hands the tag to the output register; it waits there while
// tag.ready is low. Reset clears the accumulator, the key registers and the output valid.
module poly1305_mac_block_top (
	input  logic          clk,
	input  logic          arst_n,
	pmac_stream_if.sink   msg,
	pmac_stream_if.source tag,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [63:0]   cfg_data
);
	import pmac_pkg::*;

	logic [63:0] r_low_q;
	logic [63:0] r_high_q;
	logic [63:0] s_low_q;
	logic [63:0] s_high_q;
	logic        out_valid_q;
	tag_t        out_data_q;
	logic        res_valid;
	logic        res_ready;
	tag_t        res_data;
	msg_t        msg_data;

	assign msg_data = msg.data;

	// Write the key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_low_q  <= '0;
			r_high_q <= '0;
			s_low_q  <= '0;
			s_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_R_LOW:  r_low_q  <= cfg_data;
				REG_R_HIGH: r_high_q <= cfg_data;
				REG_S_LOW:  s_low_q  <= cfg_data;
				REG_S_HIGH: s_high_q <= cfg_data;
				default:    r_low_q  <= r_low_q;
			endcase
		end
	end

	pmac_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg.valid),
		.msg_ready (msg.ready),
		.msg_data  (msg_data),
		.r_key     ({r_high_q, r_low_q}),
		.s_key     ({s_high_q, s_low_q}),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	// Hold the tag beat until taken
	assign res_ready = !out_valid_q || tag.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (tag.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res_data;
		end
	end

	assign tag.valid = out_valid_q;
	assign tag.data  = out_data_q;

endmodule

@@ hdl/pmac_mul.sv @@
// Shared 32x32 multiplier with a registered product and sideband
module pmac_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         op_a,
	input  logic [31:0]         op_b,
	input  pmac_pkg::mul_tag_t  req,
	output logic [63:0]         prod_s1,
	output pmac_pkg::mul_tag_t  rsp_s1
);
	import pmac_pkg::*;

	// Track which products are live
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_s1 <= '0;
		end else begin
			rsp_s1 <= req;
		end
	end

	// Register the product
	always_ff @(posedge clk) begin
		prod_s1 <= {32'b0, op_a} * {32'b0, op_b};
	end

endmodule

@@ hdl/pmac_core.sv @@
// Poly1305 block absorb and tag sequencer around the shared multiplier
`include "poly1305_mac_block_top_assert.svh"

module pmac_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             msg_valid,
	output logic             msg_ready,
	input  pmac_pkg::msg_t   msg_data,
	input  logic [127:0]     r_key,
	input  logic [127:0]     s_key,
	output logic             res_valid,
	input  logic             res_ready,
	output pmac_pkg::tag_t   res_data
);
	import pmac_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_ADD  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_RED1 = 3'd3;
	localparam logic [2:0] S_RED2 = 3'd4;
	localparam logic [2:0] S_RED3 = 3'd5;
	localparam logic [2:0] S_RED4 = 3'd6;
	localparam logic [2:0] S_TAG  = 3'd7;

	logic [2:0]   state_q;
	logic [4:0]   step_q;
	logic         last_q;
	logic [129:0] acc_q;
	logic [128:0] m_q;
	logic [130:0] h_q;
	logic [67:0]  colacc_q;
	logic [255:0] prod_q;
	logic [130:0] red_q;

	logic [4:0]   cnt;
	logic [127:0] blk;
	logic [128:0] m_pad;
	logic [127:0] r_cl;
	seq_t         ent;
	logic [31:0]  a_op;
	logic [31:0]  r_op;
	mul_tag_t     mul_req;
	logic [63:0]  mul_prod;
	mul_tag_t     mul_rsp;
	logic [67:0]  col_sum;
	logic         done_col;
	logic [130:0] red_y;
	logic [127:0] tag_sum;

	// Clamp the count and pad the block: 2^128 when full, else 0x01 after the last byte
	always_comb begin
		cnt = (msg_data.byte_count > CNT_FULL) ? CNT_FULL : msg_data.byte_count;
		blk = {msg_data.block_high, msg_data.block_low};
		for (int b = 0; b < 16; b++) begin
			if (5'(b) < cnt) begin
				m_pad[8*b +: 8] = blk[8*b +: 8];
			end else if (5'(b) == cnt) begin
				m_pad[8*b +: 8] = 8'h01;
			end else begin
				m_pad[8*b +: 8] = 8'h00;
			end
		end
		m_pad[128] = (cnt == CNT_FULL);
	end

	// Pick the operand limbs for this step of the schedule
	assign r_cl = r_key & R_CLAMP;
	assign ent  = seq_lookup(step_q);
	assign r_op = r_cl[{ent.rj, 5'b0} +: 32];

	always_comb begin
		case (ent.ai)
			3'd0:    a_op = h_q[31:0];
			3'd1:    a_op = h_q[63:32];
			3'd2:    a_op = h_q[95:64];
			3'd3:    a_op = h_q[127:96];
			3'd4:    a_op = {29'b0, h_q[130:128]};
			default: a_op = '0;
		endcase
	end

	always_comb begin
		mul_req.valid   = (state_q == S_MUL) && (step_q < MUL_STEPS);
		mul_req.col     = ent.col;
		mul_req.col_end = ent.col_end;
	end

	pmac_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.op_a    (a_op),
		.op_b    (r_op),
		.req     (mul_req),
		.prod_s1 (mul_prod),
		.rsp_s1  (mul_rsp)
	);

	assign col_sum  = colacc_q + {4'b0, mul_prod};
	assign done_col = mul_rsp.valid && mul_rsp.col_end && (mul_rsp.col == COL_LAST);
	assign red_y    = red_q + 131'd5;
	assign tag_sum  = acc_q[127:0] + s_key;

	assign msg_ready         = (state_q == S_IDLE);
	assign res_valid         = (state_q == S_TAG);
	assign res_data.tag_low  = tag_sum[63:0];
	assign res_data.tag_high = tag_sum[127:64];

	// Sequence one block: add, multiply by columns, reduce, then hand over the tag after a last block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			last_q  <= 1'b0;
			acc_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (msg_valid) begin
						if (cnt != '0) begin
							last_q  <= msg_data.last;
							state_q <= S_ADD;
						end else if (msg_data.last) begin
							state_q <= S_TAG;
						end
					end
				end
				S_ADD: begin
					step_q  <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (step_q < MUL_STEPS) begin
						step_q <= step_q + 5'd1;
					end
					if (done_col) begin
						state_q <= S_RED1;
					end
				end
				S_RED1: state_q <= S_RED2;
				S_RED2: state_q <= S_RED3;
				S_RED3: state_q <= S_RED4;
				S_RED4: begin
					acc_q   <= red_y[130] ? red_y[129:0] : red_q[129:0];
					state_q <= last_q ? S_TAG : S_IDLE;
				end
				S_TAG: begin
					if (res_ready) begin
						acc_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers: padded block, sum, product columns and reduction
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			m_q <= m_pad;
		end
		if (state_q == S_ADD) begin
			h_q      <= {1'b0, acc_q} + {2'b0, m_q};
			colacc_q <= '0;
		end else if (mul_rsp.valid) begin
			if (mul_rsp.col_end) begin
				prod_q[{mul_rsp.col, 5'b0} +: 32] <= col_sum[31:0];
				colacc_q <= {32'b0, col_sum[67:32]};
			end else begin
				colacc_q <= col_sum;
			end
		end
		case (state_q)
			// fold bits above 2^130 back in as times five
			S_RED1:  red_q <= {3'b0, prod_q[255:130], 2'b0} + {5'b0, prod_q[255:130]};
			S_RED2:  red_q <= {1'b0, prod_q[129:0]} + red_q;
			S_RED3:  red_q <= {1'b0, red_q[129:0]} + (red_q[130] ? 131'd5 : 131'd0);
			default: red_q <= red_q;
		endcase
	end

	`PMAC_ASSERT_NOW(a_acc_reduced, clk, arst_n, 1'b1, acc_q < P_MOD, "accumulator not reduced")
	`PMAC_ASSERT_NOW(a_mul_in_mul, clk, arst_n, mul_rsp.valid, state_q == S_MUL, "product outside multiply")
	`PMAC_ASSERT_NOW(a_top_carry, clk, arst_n, done_col, col_sum[67:32] == '0, "product overflow")
	`PMAC_ASSERT_NEXT(a_acc_clear, clk, arst_n, res_valid && res_ready, acc_q == '0, "acc not cleared")

endmodule
